// ----- rtl/twrb_pkg.sv -----
package twrb_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CountW = 2;
  localparam int unsigned BitPosW = 3;
  localparam int unsigned NumSendBytes = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_TURN,
    ST_RECV,
    ST_CLOSE
  } phase_t;

  typedef struct packed {
    logic              start_req;
    logic [ByteW-1:0]  byte_0;
    logic [ByteW-1:0]  byte_1;
    logic [ByteW-1:0]  byte_2;
    logic [CountW-1:0] byte_count;
    logic              read_request;
    logic              sdio_in;
  } item_t;

  typedef struct packed {
    logic             cs_n;
    logic             sck;
    logic             sdio_out;
    logic             sdio_drive;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_data;
  } result_t;

endpackage

// ----- rtl/twrb_front.sv -----
module twrb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  twrb_pkg::item_t   in_item,
  output logic              item_valid,
  input  logic              item_pop,
  output twrb_pkg::item_t   item
);

  twrb_pkg::item_t queue [twrb_pkg::QueueDepth];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  twrb_pkg::item_t classified;
  logic            push;
  logic            pop;

  // A byte count of zero is carried out as a single byte.
  always_comb begin
    classified = in_item;
    if (in_item.byte_count == '0) begin
      classified.byte_count = twrb_pkg::CountW'(1);
    end
  end

  assign in_ready   = (fill != 2'(twrb_pkg::QueueDepth));
  assign push       = in_valid && in_ready;
  assign item_valid = (fill != 2'd0);
  assign pop        = item_pop && item_valid;
  assign item       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/twrb_back.sv -----
module twrb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_pop,
  input  twrb_pkg::item_t   item,
  output logic              out_valid,
  input  logic              out_ready,
  output twrb_pkg::result_t out_data
);

  twrb_pkg::phase_t                     state;
  twrb_pkg::phase_t                     state_next;
  logic                                 clock_high;
  logic [twrb_pkg::BitPosW-1:0]         bit_pos;
  logic [twrb_pkg::CountW-1:0]          byte_pos;
  logic [twrb_pkg::ByteW-1:0]           send_bytes [twrb_pkg::NumSendBytes];
  logic [twrb_pkg::CountW-1:0]          bytes_to_send;
  logic                                 is_read;
  logic [twrb_pkg::ByteW-1:0]           rx_shift;
  logic [twrb_pkg::ByteW-1:0]           cur_byte;
  logic                                 cur_bit;
  logic                                 last_bit;
  logic                                 fire;
  twrb_pkg::result_t                    res;

  assign fire     = item_valid && (!out_valid || out_ready);
  assign item_pop = fire;

  always_comb begin
    case (byte_pos)
      2'd0:    cur_byte = send_bytes[0];
      2'd1:    cur_byte = send_bytes[1];
      2'd2:    cur_byte = send_bytes[2];
      default: cur_byte = '0;
    endcase
  end

  assign cur_bit  = cur_byte[bit_pos];
  assign last_bit = (bit_pos == '0) &&
                    (({1'b0, byte_pos} + 3'd1) >= {1'b0, bytes_to_send});

  always_comb begin
    state_next = state;
    case (state)
      twrb_pkg::ST_IDLE: begin
        if (item.start_req) begin
          state_next = twrb_pkg::ST_SEND;
        end
      end
      twrb_pkg::ST_SEND: begin
        if (!clock_high && last_bit) begin
          state_next = is_read ? twrb_pkg::ST_TURN : twrb_pkg::ST_CLOSE;
        end
      end
      twrb_pkg::ST_TURN: state_next = twrb_pkg::ST_RECV;
      twrb_pkg::ST_RECV: begin
        if (!clock_high && (bit_pos == '0)) begin
          state_next = twrb_pkg::ST_CLOSE;
        end
      end
      twrb_pkg::ST_CLOSE: state_next = twrb_pkg::ST_IDLE;
      default: state_next = twrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res = '{cs_n: 1'b1, sck: 1'b0, sdio_out: 1'b0, sdio_drive: 1'b0,
            busy_res: 1'b0, done_res: 1'b0, read_data: '0};
    case (state)
      twrb_pkg::ST_IDLE: begin
        if (item.start_req) begin
          res.cs_n     = 1'b0;
          res.busy_res = 1'b1;
        end
      end
      twrb_pkg::ST_SEND: begin
        res.cs_n     = 1'b0;
        res.busy_res = 1'b1;
        if (clock_high) begin
          res.sck        = 1'b1;
          res.sdio_drive = 1'b1;
          res.sdio_out   = cur_bit;
        end else begin
          res.sdio_drive = !(is_read && last_bit);
          res.sdio_out   = res.sdio_drive && cur_bit;
        end
      end
      twrb_pkg::ST_TURN: begin
        res.cs_n     = 1'b0;
        res.busy_res = 1'b1;
      end
      twrb_pkg::ST_RECV: begin
        res.cs_n     = 1'b0;
        res.busy_res = 1'b1;
        res.sck      = clock_high;
      end
      twrb_pkg::ST_CLOSE: begin
        res.busy_res  = 1'b1;
        res.done_res  = 1'b1;
        res.read_data = is_read ? rx_shift : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire && (state == twrb_pkg::ST_IDLE) && item.start_req) begin
      send_bytes[0] <= item.byte_0;
      send_bytes[1] <= item.byte_1;
      send_bytes[2] <= item.byte_2;
    end
    if (fire) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= twrb_pkg::ST_IDLE;
      clock_high    <= 1'b0;
      bit_pos       <= '0;
      byte_pos      <= '0;
      bytes_to_send <= twrb_pkg::CountW'(1);
      is_read       <= 1'b0;
      rx_shift      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        state <= state_next;
        case (state)
          twrb_pkg::ST_IDLE: begin
            if (item.start_req) begin
              bytes_to_send <= item.byte_count;
              is_read       <= item.read_request;
              rx_shift      <= '0;
              byte_pos      <= '0;
              bit_pos       <= '1;
              clock_high    <= 1'b1;
            end
          end
          twrb_pkg::ST_SEND: begin
            clock_high <= !clock_high;
            if (!clock_high) begin
              if (bit_pos != '0) begin
                bit_pos <= bit_pos - 3'd1;
              end else begin
                bit_pos <= '1;
                if (!last_bit) begin
                  byte_pos <= byte_pos + 2'd1;
                end
              end
            end
          end
          twrb_pkg::ST_TURN: begin
            bit_pos    <= '1;
            clock_high <= 1'b1;
          end
          twrb_pkg::ST_RECV: begin
            clock_high <= !clock_high;
            if (clock_high) begin
              rx_shift <= {rx_shift[twrb_pkg::ByteW-2:0], item.sdio_in};
            end else if (bit_pos != '0) begin
              bit_pos <= bit_pos - 3'd1;
            end
          end
          twrb_pkg::ST_CLOSE: begin
            clock_high <= 1'b0;
            bit_pos    <= '0;
            byte_pos   <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/three_wire_register_bus_master.sv -----
// Each input transfer is one bus phase tick and yields exactly one output transfer.
// An input transfer passes through two registers on its way to the output transfer: the
// tick queue and then the output register of the phase sequencer.
// Throughput is one tick per cycle while m_tready does not stall the output.
// Synchronous reset empties the queue and output register and returns the bus to idle.
module three_wire_register_bus_master (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // byte_0, byte_1, byte_2, byte_count, read_request, sdio_in, zero fill
  input  logic [twrb_pkg::InDataW-1:0]      s_tdata,
  // start_req
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // cs_n, sck, sdio_out, sdio_drive, busy_res, done_res, read_data, zero fill
  output logic [twrb_pkg::OutDataW-1:0]     m_tdata
);

  twrb_pkg::item_t   in_item;
  twrb_pkg::item_t   item;
  logic              item_valid;
  logic              item_pop;
  twrb_pkg::result_t res;

  always_comb begin
    in_item.start_req    = s_tuser;
    in_item.byte_0       = s_tdata[7:0];
    in_item.byte_1       = s_tdata[15:8];
    in_item.byte_2       = s_tdata[23:16];
    in_item.byte_count   = s_tdata[25:24];
    in_item.read_request = s_tdata[26];
    in_item.sdio_in      = s_tdata[27];
  end

  twrb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .item       (item)
  );

  twrb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .item       (item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (res)
  );

  assign m_tdata = {2'b00, res.read_data, res.done_res, res.busy_res,
                    res.sdio_drive, res.sdio_out, res.sck, res.cs_n};

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

import twrb_pkg::*;

class bus_master_scoreboard;
  phase_t           phase;
  bit               clk_hi;
  bit [2:0]         bit_pos;
  bit [1:0]         byte_pos;
  bit [ByteW-1:0]   tx_bytes [NumSendBytes];
  bit [1:0]         n_bytes;
  bit               rd_mode;
  bit [ByteW-1:0]   rx_shift;
  result_t          tick_q[$];
  int               errors;

  function new();
    phase = ST_IDLE;
    clk_hi = 1'b0;
    bit_pos = '0;
    byte_pos = '0;
    foreach (tx_bytes[k]) tx_bytes[k] = '0;
    n_bytes = 2'd1;
    rd_mode = 1'b0;
    rx_shift = '0;
    errors = 0;
  endfunction

  function bit is_idle();
    return phase == ST_IDLE;
  endfunction

  function int pending();
    return tick_q.size();
  endfunction

  // Advances the bus sequencer by one tick and queues the pin levels it produces.
  function void note_input(item_t it);
    result_t      r;
    bit [ByteW-1:0] cur;
    bit           bitv;
    bit           last;
    r = '0;
    r.cs_n = 1'b1;
    case (phase)
      ST_IDLE: begin
        if (it.start_req) begin
          tx_bytes[0] = it.byte_0;
          tx_bytes[1] = it.byte_1;
          tx_bytes[2] = it.byte_2;
          n_bytes = (it.byte_count == 2'd0) ? 2'd1 : it.byte_count;
          rd_mode = it.read_request;
          rx_shift = '0;
          byte_pos = '0;
          bit_pos = 3'd7;
          clk_hi = 1'b1;
          r.cs_n = 1'b0;
          r.busy_res = 1'b1;
          phase = ST_SEND;
        end
      end
      ST_SEND: begin
        cur = (byte_pos < NumSendBytes) ? tx_bytes[byte_pos] : '0;
        bitv = cur[bit_pos];
        last = (bit_pos == 3'd0) && ((int'(byte_pos) + 1) >= int'(n_bytes));
        r.cs_n = 1'b0;
        r.busy_res = 1'b1;
        if (clk_hi) begin
          r.sck = 1'b1;
          r.sdio_drive = 1'b1;
          r.sdio_out = bitv;
          clk_hi = 1'b0;
        end else begin
          r.sdio_drive = !(rd_mode && last);
          r.sdio_out = r.sdio_drive ? bitv : 1'b0;
          clk_hi = 1'b1;
          if (bit_pos != 3'd0) begin
            bit_pos = bit_pos - 3'd1;
          end else if (!last) begin
            bit_pos = 3'd7;
            byte_pos = byte_pos + 2'd1;
          end else begin
            phase = rd_mode ? ST_TURN : ST_CLOSE;
            bit_pos = 3'd7;
          end
        end
      end
      ST_TURN: begin
        r.cs_n = 1'b0;
        r.busy_res = 1'b1;
        bit_pos = 3'd7;
        clk_hi = 1'b1;
        phase = ST_RECV;
      end
      ST_RECV: begin
        r.cs_n = 1'b0;
        r.busy_res = 1'b1;
        if (clk_hi) begin
          r.sck = 1'b1;
          rx_shift = {rx_shift[ByteW-2:0], it.sdio_in};
          clk_hi = 1'b0;
        end else begin
          clk_hi = 1'b1;
          if (bit_pos != 3'd0) bit_pos = bit_pos - 3'd1;
          else phase = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        r.busy_res = 1'b1;
        r.done_res = 1'b1;
        r.read_data = rd_mode ? rx_shift : '0;
        phase = ST_IDLE;
        clk_hi = 1'b0;
        bit_pos = '0;
        byte_pos = '0;
      end
      default: phase = ST_IDLE;
    endcase
    tick_q.push_back(r);
  endfunction

  function void compare(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [OutDataW-1:0] word);
    result_t want;
    if (tick_q.size() == 0) begin
      $display("%0t: unexpected output transfer %0h", $time, word);
      errors++;
      return;
    end
    want = tick_q.pop_front();
    compare("cs_n", want.cs_n, word[0]);
    compare("sck", want.sck, word[1]);
    compare("sdio_out", want.sdio_out, word[2]);
    compare("sdio_drive", want.sdio_drive, word[3]);
    compare("busy_res", want.busy_res, word[4]);
    compare("done_res", want.done_res, word[5]);
    compare("read_data", want.read_data, word[13:6]);
  endfunction
endclass

module tb_top;
  localparam int CycleLimit = 400000;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;

  bus_master_scoreboard sb;
  int  cycles;
  int  stall_left;
  bit  tx_steady;
  bit  rx_steady;

  three_wire_register_bus_master uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    cycles = 0;
    stall_left = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    sb = new();
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (rx_steady || $urandom_range(0, 99) < 70) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  task automatic idle_gap();
    int n;
    int pick;
    pick = $urandom_range(0, 99);
    if (tx_steady || pick < 55) n = 0;
    else if (pick < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    repeat (n) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_tick(input item_t it);
    idle_gap();
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, it.sdio_in, it.read_request, it.byte_count,
                it.byte_2, it.byte_1, it.byte_0};
    s_tuser <= it.start_req;
    do @(posedge clk); while (!s_tready);
    sb.note_input(it);
  endtask

  function automatic item_t random_tick(bit start);
    item_t it;
    it.start_req = start;
    it.byte_0 = 8'($urandom_range(0, 255));
    it.byte_1 = 8'($urandom_range(0, 255));
    it.byte_2 = 8'($urandom_range(0, 255));
    it.byte_count = ($urandom_range(0, 15) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    it.read_request = 1'($urandom_range(0, 1));
    it.sdio_in = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Starts one transaction and keeps ticking until the bus is idle again. The line level
  // fed back is held low, held high or random; busy ticks carry stray start requests.
  task automatic run_transaction(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, input logic [1:0] cnt,
                                 input bit rd, input int line_mode);
    item_t it;
    it = random_tick(1'b1);
    it.byte_0 = b0;
    it.byte_1 = b1;
    it.byte_2 = b2;
    it.byte_count = cnt;
    it.read_request = rd;
    send_tick(it);
    while (!sb.is_idle()) begin
      it = random_tick(1'($urandom_range(0, 1)));
      if (line_mode < 2) it.sdio_in = line_mode[0];
      send_tick(it);
    end
  endtask

  initial begin
    item_t it;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    it = '1;
    it.start_req = 1'b0;
    send_tick(it);
    it = '0;
    send_tick(it);
    run_transaction(8'h00, 8'h00, 8'h00, 2'd1, 1'b0, 0);
    run_transaction(8'hFF, 8'hFF, 8'hFF, 2'd1, 1'b0, 1);
    run_transaction(8'hA5, 8'h5A, 8'h00, 2'd2, 1'b0, 2);
    run_transaction(8'hFF, 8'h00, 8'hFF, 2'd3, 1'b0, 2);
    run_transaction(8'h80, 8'h00, 8'h00, 2'd1, 1'b1, 1);
    run_transaction(8'h01, 8'hFE, 8'h7F, 2'd3, 1'b1, 0);
    run_transaction(8'hC3, 8'h3C, 8'h00, 2'd2, 1'b1, 2);
    run_transaction(8'h96, 8'h00, 8'h00, 2'd0, 1'b0, 2);
    run_transaction(8'h69, 8'h00, 8'h00, 2'd0, 1'b1, 1);
    run_transaction(8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1, 1);
    run_transaction(8'h00, 8'h00, 8'h00, 2'd3, 1'b1, 0);

    for (int i = 0; i < 850; i++) begin
      if (i % 200 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      if (i == 425) begin
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
      end
      if (sb.is_idle()) it = random_tick($urandom_range(0, 2) == 0);
      else it = random_tick($urandom_range(0, 7) == 0);
      send_tick(it);
    end
    s_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/twrb_pkg.sv
rtl/twrb_front.sv
rtl/twrb_back.sv
rtl/three_wire_register_bus_master.sv
verif/tb_top.sv
